[hdl/wdim_pkg.sv]
`timescale 1ns / 1ps

package wdim_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_RESULTS   = 16;

  // Index of a stored entry, a counter that can also hold the table depth,
  // and a counter for bindings found during one lookup.
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int FND_W = $clog2(MAX_RESULTS + 1);

  localparam int ENTRY_INDEX_W = 4;

  localparam logic [15:0] ANY16 = 16'hFFFF;
  localparam logic [7:0]  ANY8  = 8'hFF;

  localparam logic       OP_REGISTER = 1'b0;
  localparam logic       OP_LOOKUP   = 1'b1;

  localparam logic [1:0] KIND_STORED = 2'd0;
  localparam logic [1:0] KIND_FULL   = 2'd1;
  localparam logic [1:0] KIND_BIND   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] device;
    logic [7:0]  cls;
    logic [7:0]  subcls;
    logic [7:0]  progif;
    logic        handler;
  } entry_t;

  typedef struct packed {
    logic       load_item;
    logic       write_entry;
    logic       read_issue;
    logic       scan_step;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic hit;
    logic pend_vld;
    logic out_free;
    logic scan_done;
  } dp_status_t;

endpackage

[hdl/wdim_datapath.sv]
`timescale 1ns / 1ps

module wdim_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  wdim_pkg::dp_cmd_t      cmd,
  output wdim_pkg::dp_status_t   status,
  input  logic [7:0]             bus_number,
  input  logic [4:0]             slot_number,
  input  logic [2:0]             function_number,
  input  logic [15:0]            vendor_id,
  input  logic [15:0]            device_id,
  input  logic [7:0]             class_byte,
  input  logic [7:0]             subclass_byte,
  input  logic [7:0]             interface_byte,
  input  logic                   has_handler,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [3:0]             entry_index,
  output logic [7:0]             out_bus,
  output logic [4:0]             out_slot,
  output logic [2:0]             out_function,
  output logic [15:0]            out_vendor,
  output logic [15:0]            out_device,
  output logic [7:0]             out_class,
  output logic [7:0]             out_subclass,
  output logic [7:0]             out_interface,
  output logic                   last_result
);

  wdim_pkg::entry_t mem [wdim_pkg::TABLE_ENTRIES];
  wdim_pkg::entry_t rd_data;

  // Captured item.
  logic [7:0]                 item_bus;
  logic [4:0]                 item_slot;
  logic [2:0]                 item_function;
  wdim_pkg::entry_t           item;

  logic [wdim_pkg::CNT_W-1:0] count;
  logic [wdim_pkg::CNT_W-1:0] idx;
  logic [wdim_pkg::FND_W-1:0] found;
  logic [wdim_pkg::IDX_W-1:0] pend_idx;
  logic                       pend_vld;

  logic                       hit;
  logic                       echo;
  logic [wdim_pkg::IDX_W+wdim_pkg::ENTRY_INDEX_W-1:0] pend_wide;
  logic [wdim_pkg::CNT_W+wdim_pkg::ENTRY_INDEX_W-1:0] count_wide;
  logic [wdim_pkg::ENTRY_INDEX_W-1:0] index_sel;

  assign hit = rd_data.handler &&
               (rd_data.cls    == wdim_pkg::ANY8  || rd_data.cls    == item.cls)    &&
               (rd_data.subcls == wdim_pkg::ANY8  || rd_data.subcls == item.subcls) &&
               (rd_data.progif == wdim_pkg::ANY8  || rd_data.progif == item.progif) &&
               (rd_data.vendor == wdim_pkg::ANY16 || rd_data.vendor == item.vendor) &&
               (rd_data.device == wdim_pkg::ANY16 || rd_data.device == item.device);

  assign status.full      = (count == wdim_pkg::CNT_W'(wdim_pkg::TABLE_ENTRIES));
  assign status.hit       = hit;
  assign status.pend_vld  = pend_vld;
  assign status.out_free  = !out_valid || !out_stall;
  assign status.scan_done = (idx >= count) ||
                            (found >= wdim_pkg::FND_W'(wdim_pkg::MAX_RESULTS));

  assign pend_wide  = {{wdim_pkg::ENTRY_INDEX_W{1'b0}}, pend_idx};
  assign count_wide = {{wdim_pkg::ENTRY_INDEX_W{1'b0}}, count};

  always_comb begin
    echo = cmd.out_kind inside {wdim_pkg::KIND_BIND, wdim_pkg::KIND_NONE};
    case (cmd.out_kind)
      wdim_pkg::KIND_STORED: index_sel = count_wide[wdim_pkg::ENTRY_INDEX_W-1:0];
      wdim_pkg::KIND_BIND:   index_sel = pend_wide[wdim_pkg::ENTRY_INDEX_W-1:0];
      default:               index_sel = '0;
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      mem[count[wdim_pkg::IDX_W-1:0]] <= item;
    end
    if (cmd.read_issue) begin
      rd_data <= mem[idx[wdim_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_bus       <= bus_number;
      item_slot      <= slot_number;
      item_function  <= function_number;
      item.vendor    <= vendor_id;
      item.device    <= device_id;
      item.cls       <= class_byte;
      item.subcls    <= subclass_byte;
      item.progif    <= interface_byte;
      item.handler   <= has_handler;
    end
    if (cmd.scan_step && hit) begin
      pend_idx <= idx[wdim_pkg::IDX_W-1:0];
    end
    if (cmd.out_load) begin
      result_kind   <= cmd.out_kind;
      entry_index   <= index_sel;
      out_bus       <= echo ? item_bus      : '0;
      out_slot      <= echo ? item_slot     : '0;
      out_function  <= echo ? item_function : '0;
      out_vendor    <= echo ? item.vendor   : '0;
      out_device    <= echo ? item.device   : '0;
      out_class     <= echo ? item.cls      : '0;
      out_subclass  <= echo ? item.subcls   : '0;
      out_interface <= echo ? item.progif   : '0;
      last_result   <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      found     <= '0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.write_entry) begin
        count <= count + 1'b1;
      end
      if (cmd.load_item) begin
        idx      <= '0;
        found    <= '0;
        pend_vld <= 1'b0;
      end else if (cmd.scan_step) begin
        idx <= idx + 1'b1;
        if (hit) begin
          found    <= found + 1'b1;
          pend_vld <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/wdim_ctrl.sv]
`timescale 1ns / 1ps

module wdim_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  opcode,
  output logic                  in_stall,
  input  wdim_pkg::dp_status_t  status,
  output wdim_pkg::dp_cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_REG     = 3'd1;
  localparam logic [2:0] ST_SCAN_RD = 3'd2;
  localparam logic [2:0] ST_CHECK   = 3'd3;
  localparam logic [2:0] ST_FINAL   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = (opcode == wdim_pkg::OP_LOOKUP) ? ST_SCAN_RD : ST_REG;
        end
      end
      ST_REG: begin
        if (status.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_last    = 1'b1;
          cmd.out_kind    = status.full ? wdim_pkg::KIND_FULL : wdim_pkg::KIND_STORED;
          cmd.write_entry = !status.full;
          state_next      = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        if (status.scan_done) begin
          state_next = ST_FINAL;
        end else begin
          cmd.read_issue = 1'b1;
          state_next     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A new hit pushes the held binding out; it is not last because
        // another binding follows it.
        if (!(status.hit && status.pend_vld && !status.out_free)) begin
          cmd.scan_step = 1'b1;
          if (status.hit && status.pend_vld) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = wdim_pkg::KIND_BIND;
          end
          state_next = ST_SCAN_RD;
        end
      end
      ST_FINAL: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          cmd.out_kind = status.pend_vld ? wdim_pkg::KIND_BIND : wdim_pkg::KIND_NONE;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/wildcard_device_id_match_table_unit.sv]
`timescale 1ns / 1ps

// Wildcard device-identity match table, up to 16 driver entries.
// Input channel (in_valid / in_stall) carries one item: a register item
// (opcode 0) appends an entry, a lookup item (opcode 1) matches a
// discovered function against every stored entry. All-ones identity
// fields in an entry match anything.
// Output channel (out_valid / out_stall) carries results. A register item
// gives one stored or table-full result. A lookup gives one binding per
// matching entry with a handler, in table order, or one no-binding result;
// last_result marks the final result of each item.
// Timing: a register item's result is loaded in the ST_REG state after
// acceptance. A lookup visits a read and a check state per stored entry,
// then a final state that loads its last result, as the table sits in one
// memory with a single registered read port; output stalls add to both.
// One item is handled at a time; in_stall is high from acceptance until
// the item's last result is loaded into the output register, so the next
// item may enter while that result still waits. A stalled output holds its
// result and pauses the scan when a further binding is found.
// Reset empties the table (entry count to zero) and clears both channels.
module wildcard_device_id_match_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  bus_number,
  input  logic [4:0]  slot_number,
  input  logic [2:0]  function_number,
  input  logic [15:0] vendor_id,
  input  logic [15:0] device_id,
  input  logic [7:0]  class_byte,
  input  logic [7:0]  subclass_byte,
  input  logic [7:0]  interface_byte,
  input  logic        has_handler,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [3:0]  entry_index,
  output logic [7:0]  out_bus,
  output logic [4:0]  out_slot,
  output logic [2:0]  out_function,
  output logic [15:0] out_vendor,
  output logic [15:0] out_device,
  output logic [7:0]  out_class,
  output logic [7:0]  out_subclass,
  output logic [7:0]  out_interface,
  output logic        last_result
);

  wdim_pkg::dp_cmd_t    cmd;
  wdim_pkg::dp_status_t status;

  wdim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  wdim_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .bus_number      (bus_number),
    .slot_number     (slot_number),
    .function_number (function_number),
    .vendor_id       (vendor_id),
    .device_id       (device_id),
    .class_byte      (class_byte),
    .subclass_byte   (subclass_byte),
    .interface_byte  (interface_byte),
    .has_handler     (has_handler),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .entry_index     (entry_index),
    .out_bus         (out_bus),
    .out_slot        (out_slot),
    .out_function    (out_function),
    .out_vendor      (out_vendor),
    .out_device      (out_device),
    .out_class       (out_class),
    .out_subclass    (out_subclass),
    .out_interface   (out_interface),
    .last_result     (last_result)
  );

endmodule

[hdl/wdim_checker.sv]
`timescale 1ns / 1ps

module wdim_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        opcode,
  input logic [7:0]  bus_number,
  input logic [4:0]  slot_number,
  input logic [2:0]  function_number,
  input logic [15:0] vendor_id,
  input logic [15:0] device_id,
  input logic [7:0]  class_byte,
  input logic [7:0]  subclass_byte,
  input logic [7:0]  interface_byte,
  input logic        has_handler,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [3:0]  entry_index,
  input logic [7:0]  out_bus,
  input logic [4:0]  out_slot,
  input logic [2:0]  out_function,
  input logic [15:0] out_vendor,
  input logic [15:0] out_device,
  input logic [7:0]  out_class,
  input logic [7:0]  out_subclass,
  input logic [7:0]  out_interface,
  input logic        last_result
);

  // No result can be pending right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result visible right after reset");

  // A held result keeps its kind, index and marker.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
      $stable(entry_index) && $stable(last_result) && $stable(out_vendor))
    else $error("stalled result changed");

  // Register results are always final and carry no echoed identity.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == wdim_pkg::KIND_STORED ||
                  result_kind == wdim_pkg::KIND_FULL) |->
      last_result && out_bus == 8'd0 && out_vendor == 16'd0 && out_device == 16'd0)
    else $error("malformed register result");

  // A no-binding result is final and points at entry zero; a table-full
  // result also points at entry zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == wdim_pkg::KIND_NONE ||
                  result_kind == wdim_pkg::KIND_FULL) |->
      last_result && entry_index == 4'd0)
    else $error("malformed no-binding or full result");

  // While a lookup still owes results the block takes no new item.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> in_stall)
    else $error("new item accepted in the middle of a lookup");

endmodule

bind wildcard_device_id_match_table_unit wdim_checker u_wdim_checker (.*);
